[hw/rtl/lru_chunk_cache_lookup_assert.svh]
// Assertion macros used by the RTL of the chunk cache lookup.
// LCL_ASSERT checks a property with reset applied as a disable condition.
// LCL_ASSERT_ALWAYS checks a property at every edge, reset included.
`ifndef LRU_CHUNK_CACHE_LOOKUP_ASSERT_SVH
`define LRU_CHUNK_CACHE_LOOKUP_ASSERT_SVH

`ifndef ASSERT_OFF
`define LCL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define LCL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define LCL_ASSERT(lbl, clk, rstn, prop)
`define LCL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/lcl_pkg.sv]
package lcl_pkg;

  localparam int unsigned NumSlotsDefault = 32;
  localparam int unsigned KeyW = 16;
  localparam int unsigned SlotW = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESP
  } lcl_state_e;

endpackage

[hw/rtl/lcl_ram.sv]
module lcl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lru_chunk_cache_lookup.sv]
// Channel   | Ports                              | Handshake
// ----------+------------------------------------+---------------------------------
// request   | clip_id_i, chunk_number_i          | start high while busy is low
// result    | hit_o, slot_o                      | done_o high for one cycle
//
// A request passes through the scan, decide, update and response states in that order.
// A tag scan reads one slot per cycle from the tag and rank memories, then a second
// pass through the rank memory rewrites every rank, one slot per cycle.
// Reset leaves all slots invalid and every rank equal to its slot number, at once.
// busy stays high from the accepting edge through the cycle in which done_o is high.
// The receiver cannot stall: each result is marked valid by done_o for exactly one cycle.
`include "lru_chunk_cache_lookup_assert.svh"

module lru_chunk_cache_lookup #(
  parameter int unsigned NUM_SLOTS = lcl_pkg::NumSlotsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [lcl_pkg::KeyW-1:0]   clip_id_i,
  input  logic [lcl_pkg::KeyW-1:0]   chunk_number_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic [lcl_pkg::SlotW-1:0]  slot_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = SW + 1;
  localparam int unsigned TagW = 2 * lcl_pkg::KeyW;
  localparam logic [CW-1:0] CntEnd = CW'(NUM_SLOTS);
  localparam logic [SW-1:0] OldestRank = SW'(NUM_SLOTS - 1);

  lcl_pkg::lcl_state_e state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     pend_q, pend_d;
  logic [SW-1:0]            pa_q, pa_d;
  logic [lcl_pkg::KeyW-1:0] clip_q, clip_d;
  logic [lcl_pkg::KeyW-1:0] chunk_q, chunk_d;
  logic                     hit_q, hit_d;
  logic [SW-1:0]            best_q, best_d;
  logic [SW-1:0]            found_q, found_d;
  logic [SW-1:0]            victim_q, victim_d;
  logic [SW-1:0]            frank_q, frank_d;
  logic [NUM_SLOTS-1:0]     valid_q, valid_d;
  logic [NUM_SLOTS-1:0]     rwr_q, rwr_d;

  logic            tag_we;
  logic [TagW-1:0] tag_rdata;
  logic            rank_we;
  logic [SW-1:0]   rank_wdata;
  logic [SW-1:0]   rank_rdata;
  logic [SW-1:0]   rd_addr;
  logic [SW-1:0]   eff_rank;
  logic            tag_match;

  lcl_ram #(
    .Width (TagW),
    .Depth (NUM_SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (victim_q),
    .wdata_i ({clip_q, chunk_q}),
    .raddr_i (rd_addr),
    .rdata_o (tag_rdata)
  );

  lcl_ram #(
    .Width (SW),
    .Depth (NUM_SLOTS)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (pa_q),
    .wdata_i (rank_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rank_rdata)
  );

  // A rank entry that was never written reads as its reset value, the slot number.
  assign eff_rank  = rwr_q[pa_q] ? rank_rdata : pa_q;
  assign tag_match = valid_q[pa_q] && (tag_rdata == {clip_q, chunk_q});
  assign rd_addr   = cnt_q[SW-1:0];

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pa_d       = cnt_q[SW-1:0];
    clip_d     = clip_q;
    chunk_d    = chunk_q;
    hit_d      = hit_q;
    best_d     = best_q;
    found_d    = found_q;
    victim_d   = victim_q;
    frank_d    = frank_q;
    valid_d    = valid_q;
    rwr_d      = rwr_q;
    tag_we     = 1'b0;
    rank_we    = 1'b0;
    rank_wdata = eff_rank;
    case (state_q)
      lcl_pkg::ST_IDLE: begin
        if (start) begin
          clip_d  = clip_id_i;
          chunk_d = chunk_number_i;
          cnt_d   = '0;
          hit_d   = 1'b0;
          state_d = lcl_pkg::ST_SCAN;
        end
      end
      lcl_pkg::ST_SCAN: begin
        if (cnt_q != CntEnd) begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end else begin
          state_d = lcl_pkg::ST_DECIDE;
        end
        if (pend_q) begin
          if (tag_match && (!hit_q || (eff_rank < best_q))) begin
            hit_d   = 1'b1;
            best_d  = eff_rank;
            found_d = pa_q;
          end
          if (eff_rank == OldestRank) begin
            victim_d = pa_q;
          end
        end
      end
      lcl_pkg::ST_DECIDE: begin
        if (hit_q) begin
          frank_d = best_q;
        end else begin
          found_d           = victim_q;
          frank_d           = OldestRank;
          tag_we            = 1'b1;
          valid_d[victim_q] = 1'b1;
        end
        cnt_d   = '0;
        state_d = lcl_pkg::ST_UPDATE;
      end
      lcl_pkg::ST_UPDATE: begin
        if (cnt_q != CntEnd) begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end else begin
          state_d = lcl_pkg::ST_RESP;
        end
        if (pend_q) begin
          rank_we     = 1'b1;
          rwr_d[pa_q] = 1'b1;
          if (pa_q == found_q) begin
            rank_wdata = '0;
          end else if (eff_rank < frank_q) begin
            rank_wdata = eff_rank + SW'(1);
          end
        end
      end
      lcl_pkg::ST_RESP: begin
        state_d = lcl_pkg::ST_IDLE;
      end
      default: begin
        state_d = lcl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcl_pkg::ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      valid_q <= '0;
      rwr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      valid_q <= valid_d;
      rwr_q   <= rwr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q     <= pa_d;
    clip_q   <= clip_d;
    chunk_q  <= chunk_d;
    best_q   <= best_d;
    found_q  <= found_d;
    victim_q <= victim_d;
    frank_q  <= frank_d;
  end

  assign busy   = (state_q != lcl_pkg::ST_IDLE);
  assign done_o = (state_q == lcl_pkg::ST_RESP);
  assign hit_o  = hit_q;
  assign slot_o = lcl_pkg::SlotW'(found_q);

  `LCL_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `LCL_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> (busy && !done_o))
  `LCL_ASSERT(a_miss_valid, clk_i, rst_ni, (done_o && !hit_o) |-> valid_q[found_q])
  `LCL_ASSERT(a_done_after_update, clk_i, rst_ni,
              done_o |-> ($past(state_q) == lcl_pkg::ST_UPDATE))
  `LCL_ASSERT_ALWAYS(a_done_busy, clk_i, done_o |-> busy)

endmodule
